FILE: src/keyframe_linear_interpolator_unit_macros.svh
// Assertion helpers shared by the interpolator modules.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define KLI_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define KLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/kli_pkg.sv
package kli_pkg;

   localparam int TIME_W     = 11;
   localparam int ROW_W      = 5;
   localparam int TABLE_ROWS = 32;
   localparam int FRAC_W     = 9;
   localparam int REM_W      = TIME_W + 1;
   localparam int OFFSET_W   = 6;
   localparam int SCALE_W    = 9;
   localparam int PCT_W      = 8;
   localparam int REST_W     = 5;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [REST_W-1:0] REST_RESET = 5'd12;
   localparam logic [FRAC_W-1:0] FRAC_ONE   = 9'd256;
   localparam logic [PCT_W-1:0]  SCALE_MAX  = 8'd125;

   // percent to 1/256 units: s * 256 / 100 == (s * 5243) >> 11 for s below 170
   localparam int SCALE_RECIP = 5243;
   localparam int SCALE_SHIFT = 11;
   localparam int SCALE_PROD_W = 21;

   localparam int BOUNCE_DEPTH = 16;

   typedef struct packed {
      logic        [TIME_W-1:0]   t;
      logic signed [OFFSET_W-1:0] ty;
      logic        [PCT_W-1:0]    sx;
      logic        [PCT_W-1:0]    sy;
   } kf_row_type;

   typedef struct packed {
      logic signed [OFFSET_W-1:0] ty_a;
      logic signed [OFFSET_W-1:0] ty_b;
      logic        [PCT_W-1:0]    sx_a;
      logic        [PCT_W-1:0]    sx_b;
      logic        [PCT_W-1:0]    sy_a;
      logic        [PCT_W-1:0]    sy_b;
   } kf_pair_type;

   typedef struct packed {
      logic [TIME_W-1:0] d;
      logic [TIME_W-1:0] span;
      kf_pair_type       pair;
   } seg_type;

   typedef struct packed {
      logic [FRAC_W-1:0] frac;
      kf_pair_type       pair;
   } frac_type;

   // first field in the high bits
   typedef struct packed {
      logic [SCALE_W-1:0]  scale_y;
      logic [SCALE_W-1:0]  scale_x;
      logic [OFFSET_W-1:0] offset_y;
   } result_type;

   function automatic kf_row_type kf_row(input logic [ROW_W-1:0] idx);
      kf_row_type r;
      unique case (idx)
         5'd0:    r = '{11'd0,    6'sd0,                    8'd100, 8'd100};
         5'd1:    r = '{11'd75,   6'sd0,                    8'd115, 8'd85};
         5'd2:    r = '{11'd180,  -OFFSET_W'(BOUNCE_DEPTH), 8'd82,  8'd118};
         5'd3:    r = '{11'd330,  6'sd0,                    8'd125, 8'd78};
         5'd4:    r = '{11'd420,  6'sd0,                    8'd100, 8'd100};
         5'd5:    r = '{11'd510,  -6'sd10,                  8'd88,  8'd112};
         5'd6:    r = '{11'd645,  6'sd0,                    8'd118, 8'd85};
         5'd7:    r = '{11'd735,  6'sd0,                    8'd100, 8'd100};
         5'd8:    r = '{11'd825,  -6'sd5,                   8'd94,  8'd106};
         5'd9:    r = '{11'd945,  6'sd0,                    8'd110, 8'd92};
         default: r = '{11'd1050, 6'sd0,                    8'd100, 8'd100};
      endcase
      return r;
   endfunction

endpackage

FILE: src/kli_seg_select.sv
`include "keyframe_linear_interpolator_unit_macros.svh"

module kli_seg_select #(
   parameter int FRAME_COUNT = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [kli_pkg::TIME_W-1:0] in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output kli_pkg::seg_type          out_data
);
   import kli_pkg::*;

   logic [2:0] valid_ff;
   logic [3:0] rdy;

   logic [TIME_W-1:0]      v1_ff;
   logic [FRAME_COUNT-1:0] hit_ff;
   logic [FRAME_COUNT-1:0] hit_in;

   logic [TIME_W-1:0] v2_ff;
   logic [ROW_W-1:0]  ia_ff, ib_ff;
   logic [ROW_W-1:0]  ia_in, ib_in;
   logic              found;

   kf_row_type ra, rb, rk;
   seg_type    seg_ff, seg_in;

   always_comb begin
      rdy[3] = out_ready;
      for (int k = 0; k < 3; k++) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end
   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[2];
   assign out_data  = seg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         if (rdy[1]) valid_ff[1] <= valid_ff[0];
         if (rdy[2]) valid_ff[2] <= valid_ff[1];
      end
   end

   // stage 1: compare against every keyframe time after the first
   always_comb begin
      for (int i = 0; i < FRAME_COUNT; i++) begin
         rk        = kf_row(ROW_W'(i));
         hit_in[i] = (i != 0) && (in_data <= rk.t);
      end
   end

   // stage 2: first keyframe at or after the time (the last keyframe if none)
   always_comb begin
      found = 1'b0;
      ib_in = ROW_W'(FRAME_COUNT - 1);
      for (int i = 1; i < FRAME_COUNT; i++) begin
         if (!found && hit_ff[i]) begin
            ib_in = ROW_W'(i);
            found = 1'b1;
         end
      end
      ia_in = found ? ib_in - ROW_W'(1) : ib_in;
   end

   // stage 3: fetch both ends; a held pose divides 1 by 1 to give unity
   always_comb begin
      ra = kf_row(ia_ff);
      rb = kf_row(ib_ff);
      seg_in.pair = '{ra.ty, rb.ty, ra.sx, rb.sx, ra.sy, rb.sy};
      if (ia_ff == ib_ff) begin
         seg_in.d    = TIME_W'(1);
         seg_in.span = TIME_W'(1);
      end else begin
         seg_in.d    = v2_ff - ra.t;
         seg_in.span = rb.t - ra.t;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         v1_ff  <= in_data;
         hit_ff <= hit_in;
      end
      if (rdy[1]) begin
         v2_ff <= v1_ff;
         ia_ff <= ia_in;
         ib_ff <= ib_in;
      end
      if (rdy[2]) seg_ff <= seg_in;
   end

   `KLI_ASSERT_IMPLIES(a_seg_bounds, clock, reset, out_valid,
      (out_data.span != '0) && (out_data.d <= out_data.span), "segment offset past span")

endmodule

FILE: src/kli_frac_div.sv
`include "keyframe_linear_interpolator_unit_macros.svh"

module kli_frac_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  kli_pkg::seg_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output kli_pkg::frac_type out_data
);
   import kli_pkg::*;

   localparam int STAGES = FRAC_W;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES:0]   rdy;

   logic [REM_W-1:0]  rem_ff   [STAGES];
   logic [TIME_W-1:0] span_ff  [STAGES];
   logic [FRAC_W-1:0] frac_ff  [STAGES];
   kf_pair_type       pair_ff  [STAGES];

   logic [REM_W-1:0]  rem_src  [STAGES];
   logic [TIME_W-1:0] span_src [STAGES];
   logic [FRAC_W-1:0] frac_src [STAGES];
   kf_pair_type       pair_src [STAGES];
   logic [STAGES-1:0] valid_src;

   assign rdy[STAGES] = out_ready;
   assign in_ready    = rdy[0];
   assign out_valid   = valid_ff[STAGES-1];
   assign out_data    = '{frac_ff[STAGES-1], pair_ff[STAGES-1]};

   // restoring division, one quotient bit per stage, MSB first
   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic [REM_W-1:0]  diff;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [FRAC_W-1:0] frac_in;

      if (k == 0) begin : g_head
         assign rem_src[k]   = {1'b0, in_data.d};
         assign span_src[k]  = in_data.span;
         assign frac_src[k]  = '0;
         assign pair_src[k]  = in_data.pair;
         assign valid_src[k] = in_valid;
      end else begin : g_body
         assign rem_src[k]   = rem_ff[k-1];
         assign span_src[k]  = span_ff[k-1];
         assign frac_src[k]  = frac_ff[k-1];
         assign pair_src[k]  = pair_ff[k-1];
         assign valid_src[k] = valid_ff[k-1];
      end

      assign rdy[k] = !valid_ff[k] || rdy[k+1];

      always_comb begin
         ge      = rem_src[k] >= {1'b0, span_src[k]};
         diff    = ge ? rem_src[k] - {1'b0, span_src[k]} : rem_src[k];
         rem_in  = {diff[REM_W-2:0], 1'b0};
         frac_in = frac_src[k];
         frac_in[FRAC_W-1-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            valid_ff[k] <= valid_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            rem_ff[k]  <= rem_in;
            span_ff[k] <= span_src[k];
            frac_ff[k] <= frac_in;
            pair_ff[k] <= pair_src[k];
         end
      end
   end

   `KLI_ASSERT_IMPLIES(a_frac_range, clock, reset, out_valid,
      out_data.frac <= FRAC_ONE, "fraction above unity")

endmodule

FILE: src/kli_blend.sv
`include "keyframe_linear_interpolator_unit_macros.svh"

module kli_blend (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [kli_pkg::REST_W-1:0] rest_offset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  kli_pkg::frac_type          in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output kli_pkg::result_type        out_data
);
   import kli_pkg::*;

   logic [2:0] valid_ff;
   logic [3:0] rdy;

   // stage 1: (b - a) * f
   logic signed [6:0]  dty;
   logic signed [8:0]  dsx, dsy;
   logic signed [9:0]  f_s;
   logic signed [16:0] pty_in, pty_ff;
   logic signed [18:0] psx_in, psx_ff, psy_in, psy_ff;
   logic signed [OFFSET_W-1:0] ty_a_ff;
   logic [PCT_W-1:0]           sx_a_ff, sy_a_ff;

   // stage 2: a + product / 256, truncated toward zero; rest_offset added to the offset
   logic signed [16:0] qty;
   logic signed [18:0] qsx, qsy;
   logic signed [6:0]  ty_blend, oy_sum;
   logic signed [9:0]  sx_sum, sy_sum;
   logic [OFFSET_W-1:0] oy_in, oy_ff, oy2_ff;
   logic [PCT_W-1:0]    sx_blend_in, sx_blend_ff, sy_blend_in, sy_blend_ff;

   // stage 3: percent to 1/256 scale
   logic [SCALE_PROD_W-1:0] sx_prod_in, sx_prod_ff, sy_prod_in, sy_prod_ff;

   always_comb begin
      rdy[3] = out_ready;
      for (int k = 0; k < 3; k++) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end
   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         if (rdy[1]) valid_ff[1] <= valid_ff[0];
         if (rdy[2]) valid_ff[2] <= valid_ff[1];
      end
   end

   always_comb begin
      f_s    = $signed({1'b0, in_data.frac});
      dty    = $signed({in_data.pair.ty_b[OFFSET_W-1], in_data.pair.ty_b})
             - $signed({in_data.pair.ty_a[OFFSET_W-1], in_data.pair.ty_a});
      dsx    = $signed({1'b0, in_data.pair.sx_b}) - $signed({1'b0, in_data.pair.sx_a});
      dsy    = $signed({1'b0, in_data.pair.sy_b}) - $signed({1'b0, in_data.pair.sy_a});
      pty_in = 17'(dty) * 17'(f_s);
      psx_in = 19'(dsx) * 19'(f_s);
      psy_in = 19'(dsy) * 19'(f_s);
   end

   always_comb begin
      qty = (pty_ff + (pty_ff[16] ? 17'sd255 : 17'sd0)) >>> 8;
      qsx = (psx_ff + (psx_ff[18] ? 19'sd255 : 19'sd0)) >>> 8;
      qsy = (psy_ff + (psy_ff[18] ? 19'sd255 : 19'sd0)) >>> 8;
      ty_blend    = $signed({ty_a_ff[OFFSET_W-1], ty_a_ff}) + qty[6:0];
      oy_sum      = $signed({2'b00, rest_offset}) + ty_blend;
      oy_in       = oy_sum[OFFSET_W-1:0];
      sx_sum      = $signed({2'b00, sx_a_ff}) + qsx[9:0];
      sy_sum      = $signed({2'b00, sy_a_ff}) + qsy[9:0];
      sx_blend_in = sx_sum[PCT_W-1:0];
      sy_blend_in = sy_sum[PCT_W-1:0];
   end

   always_comb begin
      sx_prod_in = SCALE_PROD_W'(sx_blend_ff) * SCALE_PROD_W'(SCALE_RECIP);
      sy_prod_in = SCALE_PROD_W'(sy_blend_ff) * SCALE_PROD_W'(SCALE_RECIP);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         pty_ff  <= pty_in;
         psx_ff  <= psx_in;
         psy_ff  <= psy_in;
         ty_a_ff <= in_data.pair.ty_a;
         sx_a_ff <= in_data.pair.sx_a;
         sy_a_ff <= in_data.pair.sy_a;
      end
      if (rdy[1]) begin
         oy_ff       <= oy_in;
         sx_blend_ff <= sx_blend_in;
         sy_blend_ff <= sy_blend_in;
      end
      if (rdy[2]) begin
         oy2_ff     <= oy_ff;
         sx_prod_ff <= sx_prod_in;
         sy_prod_ff <= sy_prod_in;
      end
   end

   assign out_data.offset_y = oy2_ff;
   assign out_data.scale_x  = sx_prod_ff[SCALE_SHIFT +: SCALE_W];
   assign out_data.scale_y  = sy_prod_ff[SCALE_SHIFT +: SCALE_W];

   `KLI_ASSERT_IMPLIES(a_scale_range, clock, reset, valid_ff[1],
      (sx_blend_ff <= SCALE_MAX) && (sy_blend_ff <= SCALE_MAX), "blended scale out of range")

endmodule

FILE: src/keyframe_linear_interpolator_unit.sv
// Channel   Direction  Word
// req       in         elapsed_ms
// rsp       out        offset_y, scale_x, scale_y
// csr       in         rest_offset (write only)
//
// One word per clock in and out while rsp_tready is high; stages are 3 segment select,
// 9 fraction divider stages at one quotient bit each, 3 blend and scale.
// Synchronous reset clears the valid bits and sets rest_offset to 12.
// Each stage holds its word while the next is full; idle stages fill up,
// so input is taken while a result waits on rsp_tready, until all are full.
module keyframe_linear_interpolator_unit #(
   parameter int KEYFRAME_COUNT = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [kli_pkg::REQ_DATA_W-1:0] req_tdata,   // [10:0] elapsed_ms
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [kli_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [5:0] offset_y, [14:6] scale_x,
                                                       // [23:15] scale_y
   input  logic                          csr_wr_en,
   input  logic [kli_pkg::REST_W-1:0]    csr_wr_data
);
   import kli_pkg::*;

   localparam int FRAME_COUNT = (KEYFRAME_COUNT < 2) ? 2 :
                                (KEYFRAME_COUNT > TABLE_ROWS) ? TABLE_ROWS : KEYFRAME_COUNT;

   logic [REST_W-1:0] rest_offset_ff;

   logic       seg_valid, seg_ready;
   seg_type    seg_data;
   logic       frac_valid, frac_ready;
   frac_type   frac_data;
   result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_offset_ff <= REST_RESET;
      end else if (csr_wr_en) begin
         rest_offset_ff <= csr_wr_data;
      end
   end

   kli_seg_select #(
      .FRAME_COUNT (FRAME_COUNT)
   ) u_seg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata[TIME_W-1:0]),
      .out_valid (seg_valid),
      .out_ready (seg_ready),
      .out_data  (seg_data)
   );

   kli_frac_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seg_valid),
      .in_ready  (seg_ready),
      .in_data   (seg_data),
      .out_valid (frac_valid),
      .out_ready (frac_ready),
      .out_data  (frac_data)
   );

   kli_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .rest_offset (rest_offset_ff),
      .in_valid    (frac_valid),
      .in_ready    (frac_ready),
      .in_data     (frac_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (result)
   );

   assign rsp_tdata = result;

endmodule
